// ===== src/window_pair_match_counter_assert.svh =====
// Assertion shorthands for the window pair match counter.
// Each macro expects clk and rst to be visible where it is used.
`ifndef WINDOW_PAIR_MATCH_COUNTER_ASSERT_SVH
`define WINDOW_PAIR_MATCH_COUNTER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define WPMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define WPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define WPMC_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wpmc_pkg.sv =====
`default_nettype none
package wpmc_pkg;

  localparam int unsigned MAX_LEN_DEFAULT = 1024;

  localparam int WL_W     = 11;
  localparam int ACTION_W = 2;
  localparam int SYM_W    = 8;
  localparam int MC_W     = 21;
  localparam int WC_W     = 11;
  localparam int MP_W     = 25;
  localparam int ST_W     = 2;

  // Growth of the count when scaled by 100 * 256 (25600 < 2**15).
  localparam int SCALE_W = 15;

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND_Q = 2'd0,
    ACT_APPEND_R = 2'd1,
    ACT_COMPUTE  = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  localparam logic [ST_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [ST_W-1:0] STATUS_NO_WINDOW = 2'd1;
  localparam logic [ST_W-1:0] STATUS_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_DIV,
    CTL_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_DRAIN
  } scan_state_t;

endpackage
`default_nettype wire

// ===== src/wpmc_store.sv =====
`default_nettype none
module wpmc_store #(
  parameter int unsigned DEPTH = wpmc_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [wpmc_pkg::SYM_W-1:0]   wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [wpmc_pkg::SYM_W-1:0]   rd_data
);
  import wpmc_pkg::*;

  logic [SYM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/wpmc_divider.sv =====
`default_nettype none
module wpmc_divider #(
  parameter int NW = 37,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quotient
);
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem, quotient[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= num;
      rem      <= '0;
      den_r    <= den;
      cnt      <= CNT_W'(NW);
    end else if (busy) begin
      quotient <= {quotient[NW-2:0], fits};
      rem      <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== src/wpmc_scan.sv =====
`default_nettype none
module wpmc_scan #(
  parameter int unsigned MAX_LEN = wpmc_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]         q_len,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]         r_len,
  input  wire logic [wpmc_pkg::WL_W-1:0]            wl,
  output logic      [$clog2(MAX_LEN)-1:0]           q_addr,
  output logic      [$clog2(MAX_LEN)-1:0]           r_addr,
  input  wire logic [wpmc_pkg::SYM_W-1:0]           q_data,
  input  wire logic [wpmc_pkg::SYM_W-1:0]           r_data,
  output logic                                      done,
  output logic      [2*$clog2(MAX_LEN+1)-1:0]       count
);
  import wpmc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = 2 * LW;
  localparam int EW = (LW > WL_W) ? LW : WL_W;

  scan_state_t state, state_next;

  logic          side_ref;   // walking diagonals that start on the reference side
  logic [LW-1:0] base;
  logic [LW-1:0] qa, ra;
  logic          head;       // current pair opens a diagonal
  logic          v1, head1;  // compare stage, aligned with read data
  logic [LW-1:0] run;

  logic          issue;
  logic [LW-1:0] qa_inc, ra_inc, base_inc;
  logic          diag_more;
  logic          last_issue;
  logic          eq;
  logic [LW-1:0] run_next;
  logic          hit;

  assign qa_inc    = qa + LW'(1);
  assign ra_inc    = ra + LW'(1);
  assign base_inc  = base + LW'(1);
  assign diag_more = (qa_inc != q_len) && (ra_inc != r_len);
  assign last_issue = !diag_more &&
                      (side_ref ? (base_inc == r_len)
                                : ((base_inc == q_len) && (r_len == LW'(1))));

  assign q_addr = qa[AW-1:0];
  assign r_addr = ra[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      SCAN_IDLE:  if (start) state_next = SCAN_RUN;
      SCAN_RUN:   if (last_issue) state_next = SCAN_DRAIN;
      SCAN_DRAIN: if (!v1) state_next = SCAN_IDLE;
      default:    state_next = SCAN_IDLE;
    endcase
  end

  always_comb begin
    issue = 1'b0;
    done  = 1'b0;
    case (state)
      SCAN_RUN:   issue = 1'b1;
      SCAN_DRAIN: done  = !v1;
      default: begin
        issue = 1'b0;
        done  = 1'b0;
      end
    endcase
  end

  // Compare stage: extend the run of equal symbols along the diagonal.
  assign eq       = q_data == r_data;
  assign run_next = eq ? (head1 ? LW'(1) : run + LW'(1)) : '0;
  assign hit      = eq && (EW'(run_next) >= EW'(wl));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_IDLE;
      v1    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      side_ref <= 1'b0;
      base     <= '0;
      qa       <= '0;
      ra       <= '0;
      head     <= 1'b1;
    end else if (issue) begin
      if (diag_more) begin
        qa   <= qa_inc;
        ra   <= ra_inc;
        head <= 1'b0;
      end else begin
        head <= 1'b1;
        if (side_ref) begin
          base <= base_inc;
          qa   <= '0;
          ra   <= base_inc;
        end else if (base_inc != q_len) begin
          base <= base_inc;
          qa   <= base_inc;
          ra   <= '0;
        end else begin
          side_ref <= 1'b1;
          base     <= LW'(1);
          qa       <= '0;
          ra       <= LW'(1);
        end
      end
    end
    head1 <= head;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= '0;
    end else if (v1 && hit) begin
      count <= count + CW'(1);
    end
    if (v1) begin
      run <= run_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/window_pair_match_counter.sv =====
// Window pair match counter.
// Input channel (in_valid/in_ready) takes one word per handshake: an action and a
// symbol. Appends and clear give no result. A compute word
// counts the pairs of equal windows of window_length symbols between the query
// and the reference store, and gives one result word on the output channel
// (out_valid/out_ready): match_count, window_count, match_percent and status.
// The scan reads one symbol pair per cycle from the two stores, then a restoring
// divider retires one quotient bit per cycle. A compute with no complete window skips
// both and goes to the finish state, which raises out_valid once the output is free.
// in_ready is low while a compute is running.
// The result sits in an output register: the next word is accepted while it
// waits, and a stalled receiver only blocks the next compute from finishing.
// window_length is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Reset clears both lengths, the overflow flag and the output valid, and sets
// window_length to 1. Store contents are not cleared; only written entries are read.
`default_nettype none
module window_pair_match_counter #(
  parameter int unsigned MAX_LEN = wpmc_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [wpmc_pkg::WL_W-1:0]      cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [wpmc_pkg::ACTION_W-1:0]  action,
  input  wire logic [wpmc_pkg::SYM_W-1:0]     symbol,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [wpmc_pkg::MC_W-1:0]      match_count,
  output logic      [wpmc_pkg::WC_W-1:0]      window_count,
  output logic      [wpmc_pkg::MP_W-1:0]      match_percent,
  output logic      [wpmc_pkg::ST_W-1:0]      status
);
  import wpmc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = 2 * LW;              // holds up to MAX_LEN * MAX_LEN pairs
  localparam int NW = CW + SCALE_W;        // count scaled by 100 * 256
  localparam int EW = (LW > WL_W) ? LW : WL_W;

  // Configuration and string state
  logic [WL_W-1:0] window_length;
  logic [LW-1:0]   q_len, r_len;
  logic            overflow_seen;

  ctl_state_t state, state_next;

  // Pending result, parked until the output register is free
  logic [LW-1:0]   win_r;
  logic [MC_W-1:0] pend_count;
  logic [WC_W-1:0] pend_windows;
  logic [MP_W-1:0] pend_percent;
  logic [ST_W-1:0] pend_status;

  logic accept;
  logic is_compute;
  logic scan_start, div_start, out_load;
  logic q_full, r_full, q_we, r_we;

  logic [EW-1:0] wl_e, q_e, r_e;
  logic          win_ok, scan_ok;
  logic [LW-1:0] windows_calc;

  logic [AW-1:0]    q_rd_addr, r_rd_addr;
  logic [SYM_W-1:0] q_rd_data, r_rd_data;
  logic             scan_done;
  logic [CW-1:0]    scan_count;

  logic [NW-1:0] cnt_ext, times100, num;
  logic          div_done;
  logic [NW-1:0] quotient;

  assign accept     = in_valid && in_ready;
  assign is_compute = action == ACT_COMPUTE;

  // Window count and status decode, evaluated on the compute word
  assign wl_e    = EW'(window_length);
  assign q_e     = EW'(q_len);
  assign r_e     = EW'(r_len);
  assign win_ok  = (window_length != '0) && (q_e >= wl_e);
  assign scan_ok = win_ok && (r_e >= wl_e);
  assign windows_calc = win_ok ? LW'(q_e - wl_e + EW'(1)) : '0;

  // Drop symbols once a store is full
  assign q_full = q_len == LW'(MAX_LEN);
  assign r_full = r_len == LW'(MAX_LEN);
  assign q_we   = accept && (action == ACT_APPEND_Q) && !q_full;
  assign r_we   = accept && (action == ACT_APPEND_R) && !r_full;

  // count * 100 = count * (64 + 32 + 4), then 8 fraction bits
  assign cnt_ext  = NW'(scan_count);
  assign times100 = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
  assign num      = times100 << 8;

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (accept && is_compute) begin
          state_next = scan_ok ? CTL_SCAN : CTL_FINISH;
        end
      end
      CTL_SCAN:   if (scan_done) state_next = CTL_DIV;
      CTL_DIV:    if (div_done) state_next = CTL_FINISH;
      CTL_FINISH: if (!out_valid || out_ready) state_next = CTL_IDLE;
      default:    state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    scan_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      CTL_IDLE: begin
        in_ready   = 1'b1;
        scan_start = in_valid && is_compute && scan_ok;
      end
      CTL_SCAN:   div_start = scan_done;
      CTL_FINISH: out_load  = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CTL_IDLE;
      window_length <= WL_RESET;
      q_len         <= '0;
      r_len         <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      if (accept) begin
        case (action_t'(action))
          ACT_APPEND_Q: begin
            if (q_full) overflow_seen <= 1'b1;
            else        q_len <= q_len + LW'(1);
          end
          ACT_APPEND_R: begin
            if (r_full) overflow_seen <= 1'b1;
            else        r_len <= r_len + LW'(1);
          end
          ACT_CLEAR: begin
            q_len         <= '0;
            r_len         <= '0;
            overflow_seen <= 1'b0;
          end
          default: begin
            overflow_seen <= overflow_seen;
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_compute) begin
      win_r        <= windows_calc;
      pend_windows <= WC_W'(windows_calc);
      pend_count   <= '0;
      pend_percent <= '0;
      if (overflow_seen)  pend_status <= STATUS_OVERFLOW;
      else if (!scan_ok)  pend_status <= STATUS_NO_WINDOW;
      else                pend_status <= STATUS_OK;
    end
    if (div_start) begin
      pend_count <= MC_W'(scan_count);
    end
    if (div_done) begin
      pend_percent <= quotient[MP_W-1:0];
    end
    if (out_load) begin
      match_count   <= pend_count;
      window_count  <= pend_windows;
      match_percent <= pend_percent;
      status        <= pend_status;
    end
  end

  wpmc_store #(.DEPTH(MAX_LEN)) u_query_store (
    .clk     (clk),
    .we      (q_we),
    .wr_addr (q_len[AW-1:0]),
    .wr_data (symbol),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  wpmc_store #(.DEPTH(MAX_LEN)) u_ref_store (
    .clk     (clk),
    .we      (r_we),
    .wr_addr (r_len[AW-1:0]),
    .wr_data (symbol),
    .rd_addr (r_rd_addr),
    .rd_data (r_rd_data)
  );

  wpmc_scan #(.MAX_LEN(MAX_LEN)) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .q_len  (q_len),
    .r_len  (r_len),
    .wl     (window_length),
    .q_addr (q_rd_addr),
    .r_addr (r_rd_addr),
    .q_data (q_rd_data),
    .r_data (r_rd_data),
    .done   (scan_done),
    .count  (scan_count)
  );

  wpmc_divider #(.NW(NW), .DW(LW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (win_r),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule
`default_nettype wire

// ===== src/wpmc_checker.sv =====
`default_nettype none
`include "window_pair_match_counter_assert.svh"
module wpmc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cfg_wr_en,
  input wire logic [wpmc_pkg::WL_W-1:0]      cfg_wr_data,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [wpmc_pkg::ACTION_W-1:0]  action,
  input wire logic [wpmc_pkg::SYM_W-1:0]     symbol,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [wpmc_pkg::MC_W-1:0]      match_count,
  input wire logic [wpmc_pkg::WC_W-1:0]      window_count,
  input wire logic [wpmc_pkg::MP_W-1:0]      match_percent,
  input wire logic [wpmc_pkg::ST_W-1:0]      status
);
  import wpmc_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{cfg_wr_en, cfg_wr_data, symbol};

  `WPMC_ASSERT_NEXT_ANY(a_reset_clears_out, rst, !out_valid, "out_valid after reset")

  `WPMC_ASSERT_NEXT(a_compute_blocks_input, in_valid && in_ready && action == ACT_COMPUTE,
    !in_ready, "input still ready after a compute word")

  `WPMC_ASSERT_NOW(a_no_window_zero, out_valid && window_count == '0,
    match_count == '0 && match_percent == '0, "nonzero result without windows")

  `WPMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(match_count) && $stable(match_percent) && $stable(status),
    "result changed while stalled")

endmodule

bind window_pair_match_counter wpmc_checker u_wpmc_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_wr_data   (cfg_wr_data),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .action        (action),
  .symbol        (symbol),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .match_count   (match_count),
  .window_count  (window_count),
  .match_percent (match_percent),
  .status        (status)
);
`default_nettype wire

// ===== dv/window_pair_match_counter_tb.sv =====
module window_pair_match_counter_tb;
  import wpmc_pkg::*;

  localparam int unsigned DEPTH = MAX_LEN_DEFAULT;
  // Cycles with no handshake on either channel before the run is declared hung.
  // The slowest compute here scans 1024 x 6 symbol pairs; add the receiver
  // hold-off and a wide margin.
  localparam int unsigned QUIET_LIMIT = 100000;
  // Appends and clears give no result, so let them retire before touching the
  // register.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [MC_W-1:0] pair_cnt;
    logic [WC_W-1:0] windows;
    logic [MP_W-1:0] percent;
    logic [ST_W-1:0] stat;
  } score_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [WL_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACTION_W-1:0] action = '0;
  logic [SYM_W-1:0] symbol = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MC_W-1:0] match_count;
  logic [WC_W-1:0] window_count;
  logic [MP_W-1:0] match_percent;
  logic [ST_W-1:0] status;

  // Scoreboard copy of the block state.
  logic [SYM_W-1:0] q_sym [DEPTH];
  logic [SYM_W-1:0] r_sym [DEPTH];
  int q_len = 0;
  int r_len = 0;
  bit overflow_seen = 1'b0;
  logic [WL_W-1:0] win_len = WL_RESET;

  score_t pending_scores [$];
  score_t score_want;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_hold_left = 0;
  bit idle_on = 1'b1;

  window_pair_match_counter #(
    .MAX_LEN(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .symbol       (symbol),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_count  (match_count),
    .window_count (window_count),
    .match_percent(match_percent),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    fault_count++;
    if (fault_count <= 100) $display("%0t: %s", $time, what);
  endtask

  // Count equal window pairs along each diagonal of the query x reference grid:
  // keep the run of equal symbols ending at each position and count every
  // position where that run is at least one window long.
  function automatic score_t score_strings();
    score_t s;
    longint unsigned pairs;
    longint unsigned wins;
    longint unsigned pct;
    longint d;
    longint a;
    int wl;
    int unsigned run;
    bit no_window;
    pairs = 0;
    wins = 0;
    pct = 0;
    wl = int'(win_len);
    no_window = (wl == 0) || (q_len < wl) || (r_len < wl);
    if (wl != 0 && q_len >= wl) wins = q_len - wl + 1;
    if (!no_window) begin
      for (d = -(longint'(q_len) - 1); d <= longint'(r_len) - 1; d++) begin
        run = 0;
        for (a = (d < 0) ? -d : 0; a < q_len && a + d < r_len; a++) begin
          if (q_sym[a] == r_sym[a + d]) begin
            run++;
            if (run >= wl) pairs++;
          end else begin
            run = 0;
          end
        end
      end
    end
    if (wins != 0) pct = (pairs * 25600) / wins;
    s.pair_cnt = MC_W'(pairs);
    s.windows = WC_W'(wins);
    s.percent = MP_W'(pct);
    if (overflow_seen) s.stat = STATUS_OVERFLOW;
    else if (no_window) s.stat = STATUS_NO_WINDOW;
    else s.stat = STATUS_OK;
    return s;
  endfunction

  // Advance the scoreboard by one accepted word.
  function automatic void apply_word(input action_t act, input logic [SYM_W-1:0] sym);
    case (act)
      ACT_APPEND_Q: begin
        if (q_len < DEPTH) begin
          q_sym[q_len] = sym;
          q_len++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      ACT_APPEND_R: begin
        if (r_len < DEPTH) begin
          r_sym[r_len] = sym;
          r_len++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      ACT_COMPUTE: pending_scores.push_back(score_strings());
      default: begin
        q_len = 0;
        r_len = 0;
        overflow_seen = 1'b0;
      end
    endcase
  endfunction

  // Offer one word and hold it until the block takes it. Call at a rising edge;
  // returns at the edge where the word was accepted, with valid still high.
  task automatic send_word(input action_t act, input logic [SYM_W-1:0] sym);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    symbol <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word(act, sym);
  endtask

  // Drop valid, drain every outstanding result, let trailing appends retire.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window_length(input logic [WL_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = value;
  endtask

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left != 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 11);
      end
    end
  end

  // Result checker: every result word must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("result word with no compute outstanding");
      end else begin
        score_want = pending_scores.pop_front();
        if (match_count !== score_want.pair_cnt)
          report_mismatch($sformatf("match_count %0d, want %0d", match_count,
                                    score_want.pair_cnt));
        if (window_count !== score_want.windows)
          report_mismatch($sformatf("window_count %0d, want %0d", window_count,
                                    score_want.windows));
        if (match_percent !== score_want.percent)
          report_mismatch($sformatf("match_percent %0d, want %0d", match_percent,
                                    score_want.percent));
        if (status !== score_want.stat)
          report_mismatch($sformatf("status %0d, want %0d", status, score_want.stat));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("window_pair_match_counter: mismatch");
      $finish;
    end
  end

  // Short hand-picked cases: reset window length, symbol extremes, every action,
  // compute leaving strings intact, windows longer than one side, zero window.
  task automatic test_directed_cases();
    send_word(ACT_COMPUTE, 8'h00);                 // empty strings, no window
    send_word(ACT_APPEND_Q, 8'h00);
    send_word(ACT_APPEND_Q, 8'hFF);
    send_word(ACT_APPEND_R, 8'hFF);
    send_word(ACT_APPEND_R, 8'h00);
    send_word(ACT_APPEND_R, 8'hFF);
    send_word(ACT_COMPUTE, 8'hFF);                 // reset window length of 1
    send_word(ACT_COMPUTE, 8'hA5);                 // repeat: strings unchanged
    set_window_length(WL_W'(2));
    send_word(ACT_COMPUTE, 8'h5A);
    set_window_length(WL_W'(3));
    send_word(ACT_COMPUTE, 8'h00);                 // query shorter than window
    send_word(ACT_APPEND_Q, 8'h5A);
    send_word(ACT_APPEND_Q, 8'h00);
    set_window_length(WL_W'(4));
    send_word(ACT_COMPUTE, 8'h00);                 // reference shorter than window
    send_word(ACT_CLEAR, 8'hFF);
    send_word(ACT_COMPUTE, 8'h00);
    set_window_length(WL_W'(0));
    send_word(ACT_APPEND_Q, 8'h07);
    send_word(ACT_APPEND_R, 8'h07);
    send_word(ACT_COMPUTE, 8'h00);                 // zero window length
  endtask

  // Fill a store exactly, then past the end, on each side in turn.
  task automatic test_store_full();
    int unsigned k;
    set_window_length(WL_W'(DEPTH));
    send_word(ACT_CLEAR, 8'h00);
    for (k = 0; k < DEPTH; k++) send_word(ACT_APPEND_Q, SYM_W'($urandom_range(1)));
    for (k = 0; k < 6; k++) send_word(ACT_APPEND_R, SYM_W'($urandom_range(1)));
    send_word(ACT_COMPUTE, 8'h00);                 // one query window, none in reference
    send_word(ACT_APPEND_Q, 8'hFF);                // dropped, sets overflow
    send_word(ACT_COMPUTE, 8'h00);
    set_window_length(WL_W'(2));
    send_word(ACT_COMPUTE, 8'h00);                 // overflow wins over real matches
    send_word(ACT_CLEAR, 8'h00);
    send_word(ACT_COMPUTE, 8'h00);                 // clear drops the overflow flag
    for (k = 0; k < DEPTH + 2; k++) send_word(ACT_APPEND_R, SYM_W'($urandom_range(3)));
    for (k = 0; k < 4; k++) send_word(ACT_APPEND_Q, SYM_W'($urandom_range(3)));
    set_window_length(WL_W'(2047));
    send_word(ACT_COMPUTE, 8'h00);
    set_window_length(WL_W'(1));
    send_word(ACT_COMPUTE, 8'h00);
    send_word(ACT_CLEAR, 8'h00);
  endtask

  // Hold the receiver off while computes keep coming, so a finished result
  // blocks the next one and the input channel stalls.
  task automatic test_output_backpressure();
    int unsigned k;
    set_window_length(WL_W'(1));
    send_word(ACT_CLEAR, 8'h00);
    for (k = 0; k < 6; k++) begin
      send_word(ACT_APPEND_Q, SYM_W'(k % 3));
      send_word(ACT_APPEND_R, SYM_W'(k % 2));
    end
    rx_hold_left = HOLD_OFF_CYCLES;
    for (k = 0; k < 4; k++) begin
      send_word(ACT_COMPUTE, SYM_W'($urandom));
      send_word(ACT_APPEND_Q, SYM_W'($urandom_range(2)));
    end
  endtask

  function automatic logic [WL_W-1:0] pick_window_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) return '0;
    if (pick < 10) return WL_W'($urandom);
    if (pick < 14) return WL_W'($urandom_range(7, 30));
    return WL_W'($urandom_range(1, 5));
  endfunction

  // One session: clear, then a few rounds of appends each closed by a compute.
  // Most symbols come from a small random alphabet so windows actually match;
  // some sessions mirror the query into the reference so long windows hit too.
  // A few words are noise: any action, any symbol.
  task automatic random_session(output int unsigned words);
    logic [SYM_W-1:0] alphabet [4];
    logic [SYM_W-1:0] mirror_buf [$];
    logic [SYM_W-1:0] sym;
    int unsigned kind;
    int unsigned letters;
    int unsigned rounds;
    int unsigned n;
    int unsigned pick;
    int unsigned k;
    words = 0;
    for (k = 0; k < 4; k++) alphabet[k] = SYM_W'($urandom);
    kind = $urandom_range(9);
    letters = $urandom_range(1, 4);
    send_word(ACT_CLEAR, SYM_W'($urandom));
    words++;
    rounds = $urandom_range(1, 3);
    repeat (rounds) begin
      n = $urandom_range(0, 14);
      mirror_buf.delete();
      repeat (n) begin
        pick = $urandom_range(99);
        sym = (kind == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(letters - 1)];
        if (pick < 8) begin
          send_word(action_t'($urandom_range(3)), SYM_W'($urandom));
        end else if (kind == 1 || pick < 54) begin
          send_word(ACT_APPEND_Q, sym);
          mirror_buf.push_back(sym);
        end else begin
          send_word(ACT_APPEND_R, sym);
        end
        words++;
      end
      if (kind == 1) begin
        while (mirror_buf.size() != 0) begin
          send_word(ACT_APPEND_R, mirror_buf.pop_front());
          words++;
        end
      end
      send_word(ACT_COMPUTE, SYM_W'($urandom));
      words++;
    end
  endtask

  task automatic test_random_sessions(input int unsigned word_budget);
    int unsigned sent;
    int unsigned session;
    int unsigned words;
    sent = 0;
    session = 0;
    while (sent < word_budget) begin
      // Run a stretch of sessions with both sides always ready.
      idle_on = !(session >= 4 && session < 12);
      if (session % 3 == 0) set_window_length(pick_window_length());
      random_session(words);
      sent += words;
      session++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_store_full();
    test_output_backpressure();
    test_random_sessions(300);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fault_count == 0) begin
      $display("window_pair_match_counter: match");
    end else begin
      $display("window_pair_match_counter: mismatch");
    end
    $finish;
  end

endmodule

// ===== window_pair_match_counter.f =====
+incdir+src
src/wpmc_pkg.sv
src/wpmc_store.sv
src/wpmc_divider.sv
src/wpmc_scan.sv
src/window_pair_match_counter.sv
src/wpmc_checker.sv
dv/window_pair_match_counter_tb.sv
